// ===== rtl/wrwm_pkg.sv =====
// Shared types and constants for the weighted recency window manager.
package wrwm_pkg;

    // Defaults for the top-level parameters
    localparam int DEF_QUEUE_DEPTH = 16;
    localparam int DEF_MAX_MEMBERS = 8;
    localparam int DEF_KEY_BITS    = 48;

    // Fixed field widths
    localparam int CNT_W    = 5;   // queue index / count, covers a depth up to 31
    localparam int CMD_W    = 3;
    localparam int KIND_W   = 3;
    localparam int MC_W     = 4;
    localparam int CAP_W    = 8;
    localparam int EV_DEPTH = 32;  // events kept per command
    localparam int EV_AW    = 5;
    localparam int EV_CNT_W = 6;

    typedef enum logic [CMD_W-1:0] {
        CMD_PAIR    = 3'd0,
        CMD_CONN    = 3'd1,
        CMD_DISC    = 3'd2,
        CMD_UNPAIR  = 3'd3,
        CMD_DEMOTE  = 3'd4,
        CMD_REBAL   = 3'd5,
        CMD_READ    = 3'd6
    } cmd_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_LEAVE  = 3'd0,
        KIND_ENTER  = 3'd1,
        KIND_LIST   = 3'd2,
        KIND_DONE   = 3'd3,
        KIND_REJECT = 3'd4
    } kind_t;

    // Per-cycle operation broadcast along the cell row
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_SHL,    // cells lo..hi-1 take right neighbor, cell hi takes din
        CELL_SHR,    // cells 1..hi take left neighbor, cell 0 takes din
        CELL_WRITE,  // cell lo takes din
        CELL_SETBG   // cell lo takes din flag only
    } cell_op_t;

    typedef struct packed {
        cell_op_t           op;
        logic [CNT_W-1:0]   lo;
        logic [CNT_W-1:0]   hi;
    } cell_ctl_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FIND,
        S_REMOVE,
        S_MT,
        S_APPEND,
        S_DEMOTE,
        S_SUM_INIT,
        S_SUM,
        S_ROOM,
        S_RFCHK,
        S_READ,
        S_FIN,
        S_WW,
        S_OUT_RD,
        S_OUT
    } state_t;

    // What follows once room is made
    typedef enum logic [1:0] {
        P_APPEND_NEW,
        P_APPEND_MOVED,
        P_REFILL
    } post_t;

endpackage

// ===== rtl/wrwm_cell.sv =====
// One queue entry cell: key, weight and flag, shifting with its neighbors.
module wrwm_cell import wrwm_pkg::*;
#(
    parameter int KEY_BITS = DEF_KEY_BITS,
    parameter int POS      = 0
)
(
    input  logic                clk,
    input  cell_ctl_t           ctl,
    input  logic [KEY_BITS-1:0] din_key,
    input  logic [MC_W-1:0]     din_w,
    input  logic                din_bg,
    input  logic [KEY_BITS-1:0] left_key,
    input  logic [MC_W-1:0]     left_w,
    input  logic                left_bg,
    input  logic [KEY_BITS-1:0] right_key,
    input  logic [MC_W-1:0]     right_w,
    input  logic                right_bg,
    input  logic [KEY_BITS-1:0] search_key,
    output logic [KEY_BITS-1:0] key,
    output logic [MC_W-1:0]     w,
    output logic                bg,
    output logic                match
);

    localparam logic [CNT_W-1:0] IDX = CNT_W'(POS);

    logic [KEY_BITS-1:0] key_reg, key_next;
    logic [MC_W-1:0]     w_reg, w_next;
    logic                bg_reg, bg_next;

    // Next contents from the broadcast operation
    always_comb
    begin
        key_next = key_reg;
        w_next   = w_reg;
        bg_next  = bg_reg;
        case (ctl.op)
            CELL_SHL:
            begin
                if (IDX == ctl.hi)
                begin
                    key_next = din_key;
                    w_next   = din_w;
                    bg_next  = din_bg;
                end
                else if (IDX >= ctl.lo && IDX < ctl.hi)
                begin
                    key_next = right_key;
                    w_next   = right_w;
                    bg_next  = right_bg;
                end
            end
            CELL_SHR:
            begin
                if (IDX == '0)
                begin
                    key_next = din_key;
                    w_next   = din_w;
                    bg_next  = din_bg;
                end
                else if (IDX <= ctl.hi)
                begin
                    key_next = left_key;
                    w_next   = left_w;
                    bg_next  = left_bg;
                end
            end
            CELL_WRITE:
            begin
                if (IDX == ctl.lo)
                begin
                    key_next = din_key;
                    w_next   = din_w;
                    bg_next  = din_bg;
                end
            end
            CELL_SETBG:
            begin
                if (IDX == ctl.lo)
                    bg_next = din_bg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        w_reg   <= w_next;
        bg_reg  <= bg_next;
    end

    assign key   = key_reg;
    assign w     = w_reg;
    assign bg    = bg_reg;
    assign match = (key_reg == search_key);

endmodule

// ===== rtl/wrwm_evbuf.sv =====
// Event buffer: holds the events of one command until they are sent out.
module wrwm_evbuf import wrwm_pkg::*;
#(
    parameter int KEY_BITS = DEF_KEY_BITS
)
(
    input  logic                clk,
    input  logic                we,
    input  logic [EV_AW-1:0]    waddr,
    input  kind_t               wkind,
    input  logic [KEY_BITS-1:0] wkey,
    input  logic [MC_W-1:0]     ww,
    input  logic                wbg,
    input  logic [EV_AW-1:0]    raddr,
    output kind_t               rkind,
    output logic [KEY_BITS-1:0] rkey,
    output logic [MC_W-1:0]     rw,
    output logic                rbg
);

    localparam int WORD_W = KIND_W + KEY_BITS + MC_W + 1;

    logic [WORD_W-1:0] mem [EV_DEPTH];
    logic [WORD_W-1:0] rd_reg;

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= {wbg, ww, wkey, wkind};
        rd_reg <= mem[raddr];
    end

    assign rkind = kind_t'(rd_reg[KIND_W-1:0]);
    assign rkey  = rd_reg[KIND_W +: KEY_BITS];
    assign rw    = rd_reg[KIND_W+KEY_BITS +: MC_W];
    assign rbg   = rd_reg[WORD_W-1];

endmodule

// ===== rtl/weighted_recency_window_manager.sv =====
// Top level: command sequencer over a row of entry cells and an event buffer.
//
// Usage:
//   Commands arrive on the s_ stream (s_tuser = cmd, s_tdata = key, member
//   count, flag). One command is taken at a time: s_tready is high only while
//   the block is idle. Each command produces its leave/enter/list/reject events and
//   then a done transfer on the m_ stream, m_tlast marking the done transfer;
//   every transfer carries the window weight after the command.
//   The window capacity register is written through cfg_we/cfg_wdata; the
//   user writes it only while idle, which the block itself does not enforce.
// Operation:
//   After the accept a command runs its search, writes its done entry, sweeps
//   the final window weight and presents its first result, with window weight
//   sweeps before making room, before every refill check and at the end, each
//   reading the window entries one by one through the one read port. Shifts,
//   appends, evictions, refill checks and listed entries add a step each, and
//   each later result is first read from the event buffer. Then the block is idle.
// Reset:
//   rst_n clears the queue (empty), the window and the sequencer; capacity
//   returns to 8. Cell contents are not cleared.
// Stall:
//   While m_tready is low the current result is held and no command is taken.
module weighted_recency_window_manager import wrwm_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
    parameter int MAX_MEMBERS = DEF_MAX_MEMBERS,
    parameter int KEY_BITS    = DEF_KEY_BITS,
    localparam int IN_DW      = ((KEY_BITS + MC_W + 1 + 7) / 8) * 8,
    localparam int OUT_DW     = ((KEY_BITS + MC_W + 1 + CAP_W + 7) / 8) * 8
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // [KEY_BITS-1:0] device_key, [+3:KEY_BITS] member_count, [KEY_BITS+4] flag
    input  logic [IN_DW-1:0]       s_tdata,
    // [2:0] cmd
    input  logic [CMD_W-1:0]       s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [KEY_BITS-1:0] device_key_res, [+3:KEY_BITS] member_count_res,
    // [KEY_BITS+4] bg_flag, [KEY_BITS+12:KEY_BITS+5] window_weight
    output logic [OUT_DW-1:0]      m_tdata,
    // [2:0] kind
    output logic [KIND_W-1:0]      m_tuser,
    output logic                   m_tlast,
    input  logic                   cfg_we,
    input  logic [CAP_W-1:0]       cfg_wdata
);

    localparam int AW     = $clog2(QUEUE_DEPTH);
    localparam int SUM_RAW = $clog2(QUEUE_DEPTH * MAX_MEMBERS + 16);
    localparam int SUM_W  = (SUM_RAW > CAP_W) ? SUM_RAW : CAP_W;
    localparam logic [CNT_W-1:0] DEPTH    = CNT_W'(QUEUE_DEPTH);
    localparam logic [CNT_W-1:0] NO_INS   = '1;
    localparam logic [MC_W-1:0]  MAX_MC   = MC_W'(MAX_MEMBERS);
    localparam logic [CAP_W-1:0] CAP_RST  = CAP_W'(8);

    // Sequencer registers
    state_t              state_reg, state_next;
    state_t              ret_reg, ret_next;
    post_t               post_reg, post_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CNT_W-1:0]    start_reg, start_next;
    logic [CNT_W-1:0]    end_reg, end_next;
    logic [CAP_W-1:0]    cap_reg, cap_next;
    cmd_t                cmd_reg, cmd_next;
    logic [KEY_BITS-1:0] key_reg, key_next;
    logic [MC_W-1:0]     mc_reg, mc_next;
    logic                flag_reg, flag_next;
    logic [CNT_W-1:0]    idx_reg, idx_next;
    logic [KEY_BITS-1:0] mv_key_reg, mv_key_next;
    logic [MC_W-1:0]     mv_w_reg, mv_w_next;
    logic                mv_bg_reg, mv_bg_next;
    logic [SUM_W-1:0]    cur_reg, cur_next;
    logic [MC_W-1:0]     need_reg, need_next;
    logic [CNT_W-1:0]    i_reg, i_next;
    logic [EV_CNT_W-1:0] n_reg, n_next;
    logic [EV_AW-1:0]    o_idx_reg, o_idx_next;
    logic [CAP_W-1:0]    ww_reg, ww_next;

    // Cell row
    cell_ctl_t           ctl;
    logic [KEY_BITS-1:0] din_key;
    logic [MC_W-1:0]     din_w;
    logic                din_bg;
    logic [KEY_BITS-1:0] c_key   [QUEUE_DEPTH];
    logic [MC_W-1:0]     c_w     [QUEUE_DEPTH];
    logic                c_bg    [QUEUE_DEPTH];
    logic                c_match [QUEUE_DEPTH];

    // Single read port into the row
    logic [CNT_W-1:0]    rd_addr;
    logic [KEY_BITS-1:0] rd_key;
    logic [MC_W-1:0]     rd_w;
    logic                rd_bg;

    // Event buffer
    logic                ev_req, ev_we;
    kind_t               ev_kind;
    logic [KEY_BITS-1:0] ev_key;
    logic [MC_W-1:0]     ev_w;
    logic                ev_bg;
    kind_t               o_kind;
    logic [KEY_BITS-1:0] o_key;
    logic [MC_W-1:0]     o_w;
    logic                o_bg;

    // Search and window helpers
    logic                hit;
    logic [CNT_W-1:0]    hit_idx;
    logic                win_ok;
    logic                hit_in_win, idx_in_win;
    logic [MC_W-1:0]     in_mc;
    logic [MC_W-1:0]     raw_mc;
    logic [SUM_W-1:0]    rd_w_ext, need_ext;

    genvar g;
    generate
        for (g = 0; g < QUEUE_DEPTH; g++)
        begin : g_cell
            localparam int LI = (g == 0) ? 0 : g - 1;
            localparam int RI = (g == QUEUE_DEPTH - 1) ? g : g + 1;
            wrwm_cell #(.KEY_BITS(KEY_BITS), .POS(g)) u_cell (
                .clk        (clk),
                .ctl        (ctl),
                .din_key    (din_key),
                .din_w      (din_w),
                .din_bg     (din_bg),
                .left_key   (c_key[LI]),
                .left_w     (c_w[LI]),
                .left_bg    (c_bg[LI]),
                .right_key  (c_key[RI]),
                .right_w    (c_w[RI]),
                .right_bg   (c_bg[RI]),
                .search_key (key_reg),
                .key        (c_key[g]),
                .w          (c_w[g]),
                .bg         (c_bg[g]),
                .match      (c_match[g])
            );
        end
    endgenerate

    wrwm_evbuf #(.KEY_BITS(KEY_BITS)) u_evbuf (
        .clk   (clk),
        .we    (ev_we),
        .waddr (n_reg[EV_AW-1:0]),
        .wkind (ev_kind),
        .wkey  (ev_key),
        .ww    (ev_w),
        .wbg   (ev_bg),
        .raddr (o_idx_reg),
        .rkind (o_kind),
        .rkey  (o_key),
        .rw    (o_w),
        .rbg   (o_bg)
    );

    // Row read mux
    assign rd_key   = c_key[rd_addr[AW-1:0]];
    assign rd_w     = c_w[rd_addr[AW-1:0]];
    assign rd_bg    = c_bg[rd_addr[AW-1:0]];
    assign rd_w_ext = SUM_W'(rd_w);
    assign need_ext = SUM_W'(need_reg);

    // First matching entry below the count
    always_comb
    begin
        hit     = 1'b0;
        hit_idx = count_reg;
        for (int k = QUEUE_DEPTH - 1; k >= 0; k--)
        begin
            if (c_match[k] && (CNT_W'(k) < count_reg))
            begin
                hit     = 1'b1;
                hit_idx = CNT_W'(k);
            end
        end
    end

    assign win_ok     = (start_reg <= end_reg) && (end_reg <= count_reg);
    assign hit_in_win = win_ok && (hit_idx >= start_reg) && (hit_idx < end_reg);
    assign idx_in_win = win_ok && (idx_reg >= start_reg) && (idx_reg < end_reg);

    // Member count clamp: zero counts as one, saturate at the maximum
    assign raw_mc = s_tdata[KEY_BITS +: MC_W];
    assign in_mc  = (raw_mc == '0) ? MC_W'(1) : ((raw_mc > MAX_MC) ? MAX_MC : raw_mc);

    // Event write: dropped once the buffer is full
    assign ev_we = ev_req && (n_reg < EV_CNT_W'(EV_DEPTH));

    // Next state and datapath control
    always_comb
    begin
        state_next  = state_reg;
        ret_next    = ret_reg;
        post_next   = post_reg;
        count_next  = count_reg;
        start_next  = start_reg;
        end_next    = end_reg;
        cap_next    = cfg_we ? cfg_wdata : cap_reg;
        cmd_next    = cmd_reg;
        key_next    = key_reg;
        mc_next     = mc_reg;
        flag_next   = flag_reg;
        idx_next    = idx_reg;
        mv_key_next = mv_key_reg;
        mv_w_next   = mv_w_reg;
        mv_bg_next  = mv_bg_reg;
        cur_next    = cur_reg;
        need_next   = need_reg;
        i_next      = i_reg;
        o_idx_next  = o_idx_reg;
        ww_next     = ww_reg;
        ctl.op      = CELL_HOLD;
        ctl.lo      = '0;
        ctl.hi      = NO_INS;
        din_key     = rd_key;
        din_w       = rd_w;
        din_bg      = rd_bg;
        rd_addr     = start_reg;
        ev_req      = 1'b0;
        ev_kind     = KIND_LEAVE;
        ev_key      = rd_key;
        ev_w        = rd_w;
        ev_bg       = rd_bg;
        s_tready    = 1'b0;
        m_tvalid    = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd_next   = cmd_t'(s_tuser);
                    key_next   = s_tdata[KEY_BITS-1:0];
                    mc_next    = in_mc;
                    flag_next  = s_tdata[KEY_BITS+MC_W];
                    o_idx_next = '0;
                    state_next = S_FIND;
                end
            end

            S_FIND:
            begin
                idx_next   = hit_idx;
                state_next = S_FIN;
                case (cmd_reg)
                    CMD_PAIR:
                    begin
                        if (hit)
                            state_next = S_MT;
                        else if (count_reg >= DEPTH)
                        begin
                            ev_req  = 1'b1;
                            ev_kind = KIND_REJECT;
                            ev_key  = key_reg;
                            ev_w    = mc_reg;
                            ev_bg   = flag_reg;
                        end
                        else
                        begin
                            need_next  = mc_reg;
                            post_next  = P_APPEND_NEW;
                            ret_next   = S_ROOM;
                            state_next = S_SUM_INIT;
                        end
                    end
                    CMD_CONN:
                    begin
                        if (hit)
                        begin
                            if (!flag_reg)
                                state_next = S_REMOVE;
                            else
                            begin
                                ctl.op     = CELL_SETBG;
                                ctl.lo     = hit_idx;
                                din_bg     = 1'b0;
                                state_next = S_MT;
                            end
                        end
                    end
                    CMD_DISC:
                    begin
                        if (hit && flag_reg)
                        begin
                            ctl.op = CELL_SETBG;
                            ctl.lo = hit_idx;
                            din_bg = 1'b1;
                        end
                    end
                    CMD_UNPAIR:
                    begin
                        if (hit)
                            state_next = S_REMOVE;
                    end
                    CMD_DEMOTE:
                    begin
                        if (hit && hit_in_win)
                            state_next = S_DEMOTE;
                    end
                    CMD_REBAL:
                    begin
                        need_next  = '0;
                        post_next  = P_REFILL;
                        ret_next   = S_ROOM;
                        state_next = S_SUM_INIT;
                    end
                    CMD_READ:
                    begin
                        if (win_ok)
                        begin
                            i_next     = start_reg;
                            state_next = S_READ;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end

            // Remove an entry, then refill the window on the left
            S_REMOVE:
            begin
                ctl.op     = CELL_SHL;
                ctl.lo     = idx_reg;
                ctl.hi     = NO_INS;
                count_next = count_reg - 1'b1;
                end_next   = count_reg - 1'b1;
                if (!idx_in_win)
                    start_next = (start_reg != '0) ? start_reg - 1'b1 : '0;
                ret_next   = S_RFCHK;
                state_next = S_SUM_INIT;
            end

            // Move an entry to the tail
            S_MT:
            begin
                rd_addr     = idx_reg;
                mv_key_next = rd_key;
                mv_w_next   = rd_w;
                mv_bg_next  = rd_bg;
                ctl.op      = CELL_SHL;
                ctl.lo      = idx_reg;
                if (idx_in_win)
                begin
                    ctl.hi     = count_reg - 1'b1;
                    state_next = S_FIN;
                end
                else
                begin
                    ctl.hi     = NO_INS;
                    count_next = count_reg - 1'b1;
                    start_next = (start_reg != '0) ? start_reg - 1'b1 : '0;
                    end_next   = (end_reg != '0) ? end_reg - 1'b1 : '0;
                    need_next  = (rd_w != '0) ? rd_w : MC_W'(1);
                    post_next  = P_APPEND_MOVED;
                    ret_next   = S_ROOM;
                    state_next = S_SUM_INIT;
                end
            end

            S_APPEND:
            begin
                ctl.op = CELL_WRITE;
                ctl.lo = count_reg;
                if (post_reg == P_APPEND_NEW)
                begin
                    din_key = key_reg;
                    din_w   = mc_reg;
                    din_bg  = flag_reg;
                end
                else
                begin
                    din_key = mv_key_reg;
                    din_w   = mv_w_reg;
                    din_bg  = mv_bg_reg;
                end
                count_next = count_reg + 1'b1;
                end_next   = count_reg + 1'b1;
                state_next = S_FIN;
            end

            // Entry goes to the head, window start moves up (or to zero if it would reach the count)
            S_DEMOTE:
            begin
                rd_addr    = idx_reg;
                ctl.op     = CELL_SHR;
                ctl.hi     = idx_reg;
                start_next = ((start_reg + 1'b1) < count_reg) ? start_reg + 1'b1 : '0;
                ret_next   = S_RFCHK;
                state_next = S_SUM_INIT;
            end

            // Window weight sweep
            S_SUM_INIT:
            begin
                cur_next = '0;
                if (win_ok)
                begin
                    i_next     = start_reg;
                    state_next = S_SUM;
                end
                else
                    state_next = ret_reg;
            end

            S_SUM:
            begin
                rd_addr = i_reg;
                if (i_reg < end_reg)
                begin
                    cur_next = cur_reg + rd_w_ext;
                    i_next   = i_reg + 1'b1;
                end
                else
                    state_next = ret_reg;
            end

            // Evict from the window start until the need fits
            S_ROOM:
            begin
                rd_addr = start_reg;
                if ((cur_reg + need_ext > SUM_W'(cap_reg)) && (start_reg < end_reg) &&
                    (start_reg < count_reg))
                begin
                    ev_req   = 1'b1;
                    ev_kind  = KIND_LEAVE;
                    cur_next = cur_reg - rd_w_ext;
                    if ((start_reg + 1'b1) < count_reg)
                        start_next = start_reg + 1'b1;
                    else
                        state_next = (post_reg == P_REFILL) ? S_SUM_INIT : S_APPEND;
                end
                else
                    state_next = (post_reg == P_REFILL) ? S_SUM_INIT : S_APPEND;
                if (post_reg == P_REFILL)
                    ret_next = S_RFCHK;
            end

            // Pull the entry left of the window in if it fits
            S_RFCHK:
            begin
                rd_addr = start_reg - 1'b1;
                if ((start_reg != '0) && (start_reg <= count_reg) &&
                    (cur_reg + rd_w_ext <= SUM_W'(cap_reg)))
                begin
                    start_next = start_reg - 1'b1;
                    ev_req     = 1'b1;
                    ev_kind    = KIND_ENTER;
                    ret_next   = S_RFCHK;
                    state_next = S_SUM_INIT;
                end
                else
                    state_next = S_FIN;
            end

            S_READ:
            begin
                rd_addr = i_reg;
                if (i_reg < end_reg)
                begin
                    ev_req  = 1'b1;
                    ev_kind = KIND_LIST;
                    i_next  = i_reg + 1'b1;
                end
                else
                    state_next = S_FIN;
            end

            // Done entry, then the final window weight
            S_FIN:
            begin
                ev_req     = 1'b1;
                ev_kind    = KIND_DONE;
                ev_key     = '0;
                ev_w       = '0;
                ev_bg      = 1'b0;
                ret_next   = S_WW;
                state_next = S_SUM_INIT;
            end

            S_WW:
            begin
                ww_next    = (cur_reg > SUM_W'(8'hFF)) ? 8'hFF : CAP_W'(cur_reg);
                state_next = S_OUT;
            end

            S_OUT_RD:
            begin
                state_next = S_OUT;
            end

            // Present one result until it is taken
            S_OUT:
            begin
                m_tvalid = 1'b1;
                if (m_tready)
                begin
                    if (m_tlast)
                        state_next = S_IDLE;
                    else
                    begin
                        o_idx_next = o_idx_reg + 1'b1;
                        state_next = S_OUT_RD;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (state_reg == S_IDLE)
            n_next = s_tvalid ? '0 : n_reg;
        else
            n_next = ev_we ? n_reg + 1'b1 : n_reg;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            start_reg <= '0;
            end_reg   <= '0;
            cap_reg   <= CAP_RST;
            n_reg     <= '0;
            o_idx_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            start_reg <= start_next;
            end_reg   <= end_next;
            cap_reg   <= cap_next;
            n_reg     <= n_next;
            o_idx_reg <= o_idx_next;
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        ret_reg    <= ret_next;
        post_reg   <= post_next;
        cmd_reg    <= cmd_next;
        key_reg    <= key_next;
        mc_reg     <= mc_next;
        flag_reg   <= flag_next;
        idx_reg    <= idx_next;
        mv_key_reg <= mv_key_next;
        mv_w_reg   <= mv_w_next;
        mv_bg_reg  <= mv_bg_next;
        cur_reg    <= cur_next;
        need_reg   <= need_next;
        i_reg      <= i_next;
        ww_reg     <= ww_next;
    end

    // Output transfer; the final result always reads as done
    assign m_tlast = (EV_CNT_W'(o_idx_reg) == n_reg - 1'b1);
    assign m_tuser = m_tlast ? KIND_DONE : o_kind;
    assign m_tdata = OUT_DW'({ww_reg, o_bg, o_w, o_key});

endmodule
